// ----- src/fbc_pkg.sv -----
package fbc_pkg;

  // Program and data stores: 16 banks or pages of 16 entries each.
  localparam int ADDR_W = 8;

  // Depth of the result buffer and the width of its pointers.
  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);

  typedef logic [3:0]        nib_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Kinds of request.
  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_EXEC = 1'b1;

  typedef enum logic [3:0] {
    OPC_ADDA  = 4'h0,  // A = A + im
    OPC_MOVAB = 4'h1,  // A = B + im
    OPC_INA   = 4'h2,  // A = in + im
    OPC_LDIA  = 4'h3,  // A = im
    OPC_MOVBA = 4'h4,  // B = A + im
    OPC_ADDB  = 4'h5,  // B = B + im
    OPC_INB   = 4'h6,  // B = in + im
    OPC_LDIB  = 4'h7,  // B = im
    OPC_BANK  = 4'h8,  // ROM bank = im
    OPC_OUTB  = 4'h9,  // out B + im
    OPC_PAGE  = 4'hA,  // RAM page = im
    OPC_OUTI  = 4'hB,  // out im
    OPC_LDM   = 4'hC,  // B = ram[page][im]
    OPC_STM   = 4'hD,  // ram[page][im] = B
    OPC_JNC   = 4'hE,  // jump if no carry
    OPC_JMP   = 4'hF   // jump, halt on a jump to itself
  } opcode_t;

  typedef struct packed {
    logic       out_valid;
    logic [4:0] out_value;
    logic       took_input;
    logic       halted;
    nib_t       next_pc;
    nib_t       current_bank;
    nib_t       value_a;
    nib_t       value_b;
    logic       carry_pending;
  } result_t;

  // Access from the execute stage to the data store.
  typedef struct packed {
    logic  wr_en;
    addr_t addr;
    nib_t  wdata;
  } dmem_req_t;

endpackage

// ----- src/fbc_store.sv -----
module fbc_store #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  fbc_pkg::addr_t     wr_addr,
  input  logic [WIDTH-1:0]   wr_data,
  input  fbc_pkg::addr_t     rd_addr,
  output logic [WIDTH-1:0]   rd_data
);
  import fbc_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_vld <= written[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- src/fbc_core.sv -----
module fbc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic                operation,
  input  fbc_pkg::nib_t       in_value,
  input  logic [7:0]          prog_word,
  input  fbc_pkg::nib_t       dmem_rdata,
  output fbc_pkg::addr_t      fetch_addr,
  output fbc_pkg::dmem_req_t  dmem_req,
  output logic                push,
  output fbc_pkg::result_t    push_data
);
  import fbc_pkg::*;

  // Architectural state.
  logic [4:0] reg_a, reg_a_next;
  nib_t       reg_b, reg_b_next;
  nib_t       pc, pc_next;
  nib_t       bank, bank_next;
  nib_t       page, page_next;
  logic       halt, halt_next;

  // Execute stage.
  logic       e_valid;
  logic       e_oper;
  nib_t       e_in;

  // Write-back stage.
  logic       w_valid;
  logic       w_load_b;
  result_t    w_res;

  opcode_t    opc;
  nib_t       im;
  nib_t       a_m;
  nib_t       b_cur;
  logic       run;
  logic       ov;
  logic [4:0] oval;
  logic       took;
  logic       load_b;
  logic       st_en;
  result_t    res;

  assign opc = opcode_t'(prog_word[7:4]);
  assign im  = prog_word[3:0];
  assign a_m = reg_a[3:0];
  assign run = e_valid && (e_oper == OPER_EXEC) && !halt;

  // B as it stands once a load from the data store in write-back has landed.
  assign b_cur = (w_valid && w_load_b) ? dmem_rdata : reg_b;

  always_comb begin
    reg_a_next = reg_a;
    reg_b_next = b_cur;
    pc_next    = pc;
    bank_next  = bank;
    page_next  = page;
    halt_next  = halt;
    ov         = 1'b0;
    oval       = '0;
    took       = 1'b0;
    load_b     = 1'b0;
    st_en      = 1'b0;
    if (run) begin
      reg_a_next = {1'b0, a_m};
      pc_next    = pc + 4'd1;
      case (opc)
        OPC_ADDA: begin
          reg_a_next = {1'b0, a_m} + {1'b0, im};
        end
        OPC_MOVAB: begin
          reg_a_next = {1'b0, b_cur} + {1'b0, im};
        end
        OPC_INA: begin
          reg_a_next = {1'b0, e_in} + {1'b0, im};
          took       = 1'b1;
        end
        OPC_LDIA: begin
          reg_a_next = {1'b0, im};
        end
        OPC_MOVBA: begin
          reg_b_next = a_m + im;
        end
        OPC_ADDB: begin
          reg_b_next = b_cur + im;
        end
        OPC_INB: begin
          reg_b_next = e_in + im;
          took       = 1'b1;
        end
        OPC_LDIB: begin
          reg_b_next = im;
        end
        OPC_BANK: begin
          bank_next = im;
        end
        OPC_OUTB: begin
          ov   = 1'b1;
          oval = {1'b0, b_cur} + {1'b0, im};
        end
        OPC_PAGE: begin
          page_next = im;
        end
        OPC_OUTI: begin
          ov   = 1'b1;
          oval = {1'b0, im};
        end
        OPC_LDM: begin
          load_b = 1'b1;
        end
        OPC_STM: begin
          st_en = 1'b1;
        end
        OPC_JNC: begin
          if (!reg_a[4]) begin
            pc_next = im;
          end
        end
        OPC_JMP: begin
          if (im == pc) begin
            halt_next = 1'b1;
            pc_next   = pc;
          end else begin
            pc_next = im;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.out_valid     = ov;
    res.out_value     = oval;
    res.took_input    = took;
    res.halted        = halt_next;
    res.next_pc       = pc_next;
    res.current_bank  = bank_next;
    res.value_a       = reg_a_next[3:0];
    res.value_b       = reg_b_next;
    res.carry_pending = reg_a_next[4];
  end

  // The next fetch follows the state this instruction leaves behind.
  assign fetch_addr     = {bank_next, pc_next};
  assign dmem_req.wr_en = st_en;
  assign dmem_req.addr  = {page, im};
  assign dmem_req.wdata = b_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a    <= '0;
      reg_b    <= '0;
      pc       <= '0;
      bank     <= '0;
      page     <= '0;
      halt     <= 1'b0;
      e_valid  <= 1'b0;
      w_valid  <= 1'b0;
      w_load_b <= 1'b0;
    end else begin
      reg_a    <= reg_a_next;
      reg_b    <= reg_b_next;
      pc       <= pc_next;
      bank     <= bank_next;
      page     <= page_next;
      halt     <= halt_next;
      e_valid  <= acc;
      w_valid  <= e_valid;
      w_load_b <= load_b;
    end
  end

  always_ff @(posedge clk) begin
    e_oper <= operation;
    e_in   <= in_value;
    w_res  <= res;
  end

  always_comb begin
    push_data = w_res;
    if (w_load_b) begin
      push_data.value_b = dmem_rdata;
    end
  end

  assign push = w_valid;

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt)
    else $error("halt flag cleared without reset");

  a_halt_freezes_pc: assert property (@(posedge clk) disable iff (rst)
    halt |=> $stable(pc) && $stable(bank))
    else $error("program counter moved while halted");

  a_halt_no_carry: assert property (@(posedge clk) disable iff (rst)
    halt |-> !reg_a[4])
    else $error("carry pending while halted");

endmodule

// ----- src/fbc_out_fifo.sv -----
module fbc_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fbc_pkg::result_t  push_data,
  input  logic              pop,
  output logic              not_empty,
  output fbc_pkg::result_t  head
);
  import fbc_pkg::*;

  result_t            buf_q [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end
  end

  assign not_empty = (count != '0);
  assign head      = buf_q[rd_ptr];

endmodule

// ----- src/four_bit_banked_cpu_core.sv -----
// Four-bit banked accumulator CPU. Each request either writes one byte of the
// program store (operation low) or executes one instruction (operation high),
// and every request returns exactly one result that reports A, B, carry,
// program counter, ROM bank and halt state after it, plus the output port
// when an out instruction ran. The block accepts one request per clock while
// its eight-entry result buffer has room, so with the output side always
// ready it sustains one request per cycle; each result passes through the
// execute and write-back registers into the buffer. At full rate one
// request sits in each of those stages and one waits to be taken, so the
// buffer never throttles a steady stream. The rate is set by the loop from
// the program store's registered read port through decode to the next
// fetch address: the fetch for a request is issued at the very edge it is
// accepted, using the counter and bank that the previous instruction
// leaves. Both the 256-byte program store and the 256-nibble data store
// clear at reset through per-entry valid bits, so there is no clearing pass
// and requests are taken from the first cycle after reset.
module four_bit_banked_cpu_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic           operation,
  input  logic [3:0]     load_bank,
  input  logic [3:0]     load_index,
  input  logic [7:0]     load_byte,
  input  logic [3:0]     in_value,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output logic           out_valid,
  output logic [4:0]     out_value,
  output logic           took_input,
  output logic           halted,
  output logic [3:0]     next_pc,
  output logic [3:0]     current_bank,
  output logic [3:0]     value_a,
  output logic [3:0]     value_b,
  output logic           carry_pending
);
  import fbc_pkg::*;

  logic       acc;
  logic       pop;
  logic [PTR_W:0] occ;

  addr_t      fetch_addr;
  logic [7:0] prog_word;
  dmem_req_t  dmem_req;
  nib_t       dmem_rdata;
  logic       push;
  result_t    push_data;
  result_t    head;

  // Every accepted request holds a slot in the result buffer until its result
  // is taken, so the buffer can never overflow however long the output
  // side stalls.
  assign req_ready = (occ != OUT_DEPTH[PTR_W:0]);
  assign acc       = req_valid && req_ready;
  assign pop       = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + {{PTR_W{1'b0}}, acc} - {{PTR_W{1'b0}}, pop};
    end
  end

  // Load requests write the program store at the edge they are accepted; an
  // instruction fetched at a later edge sees the new byte.
  fbc_store #(.WIDTH(8)) u_prog_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (acc && (operation == OPER_LOAD)),
    .wr_addr ({load_bank, load_index}),
    .wr_data (load_byte),
    .rd_addr (fetch_addr),
    .rd_data (prog_word)
  );

  fbc_store #(.WIDTH(4)) u_data_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (dmem_req.wr_en),
    .wr_addr (dmem_req.addr),
    .wr_data (dmem_req.wdata),
    .rd_addr (dmem_req.addr),
    .rd_data (dmem_rdata)
  );

  fbc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .operation  (operation),
    .in_value   (in_value),
    .prog_word  (prog_word),
    .dmem_rdata (dmem_rdata),
    .fetch_addr (fetch_addr),
    .dmem_req   (dmem_req),
    .push       (push),
    .push_data  (push_data)
  );

  fbc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (rsp_valid),
    .head      (head)
  );

  assign out_valid     = head.out_valid;
  assign out_value     = head.out_value;
  assign took_input    = head.took_input;
  assign halted        = head.halted;
  assign next_pc       = head.next_pc;
  assign current_bank  = head.current_bank;
  assign value_a       = head.value_a;
  assign value_b       = head.value_b;
  assign carry_pending = head.carry_pending;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OUT_DEPTH[PTR_W:0])
    else $error("more requests in flight than result slots");

  a_rsp_has_request: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occ != '0)
    else $error("result offered with no request in flight");

  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    (acc && !pop) |=> occ == $past(occ) + 1'b1)
    else $error("accepted request not counted");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import fbc_pkg::*;

  // Each request is one of two kinds. A load request writes one byte of the
  // program store. An execute request runs the instruction at the current
  // bank and counter. Every request returns exactly one result. The
  // scoreboard below models the core one request at a time. It keeps an
  // ordered list of the results it expects and compares each result the
  // core returns with the oldest entry in that list.
  class cpu_scoreboard;
    logic [7:0] prog_mem [256];
    nib_t       data_mem [256];
    logic [4:0] acc_a;
    logic [4:0] acc_b;
    nib_t       counter;
    nib_t       bank_sel;
    nib_t       page_sel;
    logic       halt_seen;
    result_t    expected_q [$];
    int         mismatches;

    function new();
      foreach (prog_mem[i]) prog_mem[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      acc_a      = '0;
      acc_b      = '0;
      counter    = '0;
      bank_sel   = '0;
      page_sel   = '0;
      halt_seen  = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advances the model by one accepted request and queues the result that
    // the request should produce.
    function void note_request(logic oper, nib_t ld_bank, nib_t ld_idx,
                               logic [7:0] ld_byte, nib_t in_val);
      result_t    r;
      logic [7:0] word;
      opcode_t    opc;
      nib_t       im;
      nib_t       npc;
      logic       carry;
      r = '0;
      if (oper == OPER_LOAD) begin
        prog_mem[{ld_bank, ld_idx}] = ld_byte;
      end else if (!halt_seen) begin
        word  = prog_mem[{bank_sel, counter}];
        opc   = opcode_t'(word[7:4]);
        im    = word[3:0];
        // The carry is whatever the previous instruction left above the
        // low nibble of A. Both registers are cut back to four bits first.
        carry = acc_a[4];
        acc_a[4] = 1'b0;
        acc_b[4] = 1'b0;
        npc   = counter + 4'd1;
        case (opc)
          OPC_ADDA:  acc_a = acc_a + 5'(im);
          OPC_MOVAB: acc_a = acc_b + 5'(im);
          OPC_INA: begin
            acc_a = 5'(in_val) + 5'(im);
            r.took_input = 1'b1;
          end
          OPC_LDIA:  acc_a = 5'(im);
          OPC_MOVBA: acc_b = acc_a + 5'(im);
          OPC_ADDB:  acc_b = acc_b + 5'(im);
          OPC_INB: begin
            acc_b = 5'(in_val) + 5'(im);
            r.took_input = 1'b1;
          end
          OPC_LDIB:  acc_b = 5'(im);
          OPC_BANK:  bank_sel = im;
          OPC_OUTB: begin
            r.out_valid = 1'b1;
            r.out_value = acc_b + 5'(im);
          end
          OPC_PAGE:  page_sel = im;
          OPC_OUTI: begin
            r.out_valid = 1'b1;
            r.out_value = 5'(im);
          end
          OPC_LDM:   acc_b = 5'(data_mem[{page_sel, im}]);
          OPC_STM:   data_mem[{page_sel, im}] = acc_b[3:0];
          OPC_JNC:   if (!carry) npc = im;
          OPC_JMP: begin
            if (im == counter) begin
              halt_seen = 1'b1;
              npc = counter;
            end else begin
              npc = im;
            end
          end
          default: ;
        endcase
        counter = npc;
      end
      r.halted        = halt_seen;
      r.next_pc       = counter;
      r.current_bank  = bank_sel;
      r.value_a       = acc_a[3:0];
      r.value_b       = acc_b[3:0];
      r.carry_pending = acc_a[4];
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [4:0] want, logic [4:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result returned with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare("out_valid", 5'(want.out_valid), 5'(got.out_valid));
      compare("out_value", want.out_value, got.out_value);
      compare("took_input", 5'(want.took_input), 5'(got.took_input));
      compare("halted", 5'(want.halted), 5'(got.halted));
      compare("next_pc", 5'(want.next_pc), 5'(got.next_pc));
      compare("current_bank", 5'(want.current_bank), 5'(got.current_bank));
      compare("value_a", 5'(want.value_a), 5'(got.value_a));
      compare("value_b", 5'(want.value_b), 5'(got.value_b));
      compare("carry_pending", 5'(want.carry_pending), 5'(got.carry_pending));
    endfunction
  endclass

  localparam int RANDOM_REQUESTS = 1800;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  logic       operation;
  nib_t       load_bank;
  nib_t       load_index;
  logic [7:0] load_byte;
  nib_t       in_value;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  logic       out_valid;
  logic [4:0] out_value;
  logic       took_input;
  logic       halted;
  nib_t       next_pc;
  nib_t       current_bank;
  nib_t       value_a;
  nib_t       value_b;
  logic       carry_pending;

  cpu_scoreboard sb;
  int            sent;
  // While this is set neither side starts any new gaps or stalls.
  bit            calm = 1'b0;
  int            stall_left = 0;

  four_bit_banked_cpu_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .operation     (operation),
    .load_bank     (load_bank),
    .load_index    (load_index),
    .load_byte     (load_byte),
    .in_value      (in_value),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .took_input    (took_input),
    .halted        (halted),
    .next_pc       (next_pc),
    .current_bank  (current_bank),
    .value_a       (value_a),
    .value_b       (value_b),
    .carry_pending (carry_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous upper bound on the run; a hung handshake ends up here.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side back-pressure. Each stall draws its length from a short range
  // or, now and then, a long one, and during calm stretches no new stall
  // starts; one already under way runs to its end.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 15) begin
      rsp_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Results are taken at the rising edge, where the outputs still hold the
  // values from before the edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_result({out_valid, out_value, took_input, halted, next_pc,
                       current_bank, value_a, value_b, carry_pending});
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A random program byte for position idx of a bank. A jump to its own
  // position would halt the core for good, since only reset clears the halt,
  // so that one case is moved to the next position instead.
  function automatic logic [7:0] pick_byte(nib_t idx);
    logic [7:0] b;
    b = 8'($urandom);
    if (opcode_t'(b[7:4]) == OPC_JMP && b[3:0] == idx) b[3:0] = idx + 4'd1;
    return b;
  endfunction

  // Presents one request from the falling edge on and waits for the rising
  // edge at which the core accepts it. The valid line stays high straight
  // into the next request when there is no gap.
  task automatic send_request(logic oper, nib_t ld_bank, nib_t ld_idx,
                              logic [7:0] ld_byte, nib_t in_val);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= oper;
    load_bank  <= ld_bank;
    load_index <= ld_idx;
    load_byte  <= ld_byte;
    in_value   <= in_val;
    do @(posedge clk); while (!req_ready);
    sb.note_request(oper, ld_bank, ld_idx, ld_byte, in_val);
    sent++;
  endtask

  task automatic load_at(nib_t bank, nib_t idx, logic [7:0] prog_byte);
    send_request(OPER_LOAD, bank, idx, prog_byte, nib_t'($urandom_range(0, 15)));
  endtask

  // The load fields are don't-care on an execute request, so they carry noise.
  task automatic exec_step(nib_t in_val);
    send_request(OPER_EXEC, nib_t'($urandom_range(0, 15)),
                 nib_t'($urandom_range(0, 15)), 8'($urandom), in_val);
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned n;
    int          target;
    nib_t        idx;

    sb         = new();
    sent       = 0;
    rst        = 1'b1;
    req_valid  = 1'b0;
    operation  = OPER_LOAD;
    load_bank  = '0;
    load_index = '0;
    load_byte  = '0;
    in_value   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program. Both inputs at their top value push A to thirty, which
    // sets the carry so the conditional jump falls through, while B keeps only the low nibble. Then
    // the largest output value, a store and loads at the top RAM page, and a
    // bank switch into bank fifteen, where a jump and a second bank switch at
    // the last position make the counter wrap back to the start of bank zero.
    load_at(4'd0, 4'd0, {OPC_INB, 4'hF});
    load_at(4'd0, 4'd1, {OPC_INA, 4'hF});
    load_at(4'd0, 4'd2, {OPC_JNC, 4'hF});
    load_at(4'd0, 4'd3, {OPC_LDIB, 4'hF});
    load_at(4'd0, 4'd4, {OPC_OUTB, 4'hF});
    load_at(4'd0, 4'd5, {OPC_OUTI, 4'hF});
    load_at(4'd0, 4'd6, {OPC_PAGE, 4'hF});
    load_at(4'd0, 4'd7, {OPC_STM, 4'hF});
    load_at(4'd0, 4'd8, {OPC_LDM, 4'h0});
    load_at(4'd0, 4'd9, {OPC_LDM, 4'hF});
    load_at(4'd0, 4'd10, {OPC_BANK, 4'hF});
    load_at(4'd15, 4'd11, {OPC_JMP, 4'hF});
    load_at(4'd15, 4'd15, {OPC_BANK, 4'h0});
    exec_step(4'd15);
    exec_step(4'd15);
    repeat (11) exec_step(4'd0);
    exec_step(4'd0);
    drain();

    // Random part. Half of the choices rewrite some or all of the bank being
    // executed and then runs a stretch of instructions, so that every
    // opcode is reached with random operands. The rest is loads to random
    // places, plain runs over older contents, mixed requests and drains.
    target = sent + RANDOM_REQUESTS;
    while (sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          idx = nib_t'($urandom_range(0, 15));
          load_at(sb.bank_sel, idx, pick_byte(idx));
        end
        repeat ($urandom_range(8, 40)) exec_step(nib_t'($urandom_range(0, 15)));
      end else if (kind < 10) begin
        for (int i = 0; i < 16; i++) begin
          load_at(sb.bank_sel, nib_t'(i), pick_byte(nib_t'(i)));
        end
        repeat ($urandom_range(16, 48)) exec_step(nib_t'($urandom_range(0, 15)));
      end else if (kind < 14) begin
        repeat ($urandom_range(4, 30)) exec_step(nib_t'($urandom_range(0, 15)));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 4)) begin
          idx = nib_t'($urandom_range(0, 15));
          load_at(nib_t'($urandom_range(0, 15)), idx, pick_byte(idx));
        end
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 1) == 0) begin
            idx = nib_t'($urandom_range(0, 15));
            load_at(nib_t'($urandom_range(0, 15)), idx, pick_byte(idx));
          end else begin
            exec_step(nib_t'($urandom_range(0, 15)));
          end
        end
      end else begin
        drain();
      end
    end
    calm = 1'b0;
    drain();

    // Halt last of all, as nothing but reset brings the core back: a jump
    // to its own position, further execute requests that must change
    // nothing, and a load that must not clear the halt.
    load_at(sb.bank_sel, sb.counter, {OPC_JMP, sb.counter});
    exec_step(nib_t'($urandom_range(0, 15)));
    repeat (3) exec_step(nib_t'($urandom_range(0, 15)));
    load_at(sb.bank_sel, sb.counter, {OPC_LDIA, 4'h5});
    repeat (2) exec_step(nib_t'($urandom_range(0, 15)));
    drain();

    // Keep the clock running to catch any result the core should not have sent.
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
